>>> hdl/sard_pkg.sv
// Shared types and codes for the sorted address range decoder.
// Used by sorted_address_range_decoder_core; has no dependencies of its own.
package sard_pkg;

    // Widths fixed by the beat layout.
    localparam int DEV_WIDTH   = 8;
    localparam int FIELD_WIDTH = 32;
    localparam int IN_TDATA_W  = 104;
    localparam int OUT_TDATA_W = 16;

    // Item kinds carried on the input tuser bit.
    localparam logic KIND_LOOKUP = 1'b0;
    localparam logic KIND_INSERT = 1'b1;

    // Result status codes.
    localparam logic [1:0] STATUS_OK      = 2'd0;
    localparam logic [1:0] STATUS_OVERLAP = 2'd1;
    localparam logic [1:0] STATUS_FULL    = 2'd2;

    // Sequencer states.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOOKUP,
        ST_INS_SCAN,
        ST_SHIFT,
        ST_WRITE,
        ST_RESP
    } t_state;

endpackage

>>> hdl/sard_ram.sv
// Generic simple dual-port RAM: one write port, one read port with registered data.
// Depends on nothing; instantiated by the decoder core for the range table.
module sard_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                    i_clk,
    input  logic                                    i_we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                        i_wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                        o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port and registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> hdl/sorted_address_range_decoder_core.sv
// Sorted address range decoder: a table of non-overlapping ranges kept in a RAM.
// Depends on sard_pkg and sard_ram.
//
//  channel  | dir | handshake            | payload
//  ---------+-----+----------------------+------------------------------------------
//  s (item) | in  | i_s_tvalid/o_s_tready | tdata: address, first_addr, last_addr,
//           |     |                      |        device_id; tuser: kind
//  m (res)  | out | o_m_tvalid/i_m_tready | tdata: hit, device_out, status
//
// A lookup reads entries in order until the answer is known, at most
// entry_count of them; the range table RAM gives one entry per cycle.
// An insert reads entries up to its slot, then moves each later entry up one
// slot per cycle, then writes the new one. Immediate refusals and lookups on an
// empty table go straight to the result; an insert into an empty table goes
// straight to the write. Reset (synchronous, active low) empties the table at once.
// A result waits in the output register while the next beat is already taken in;
// if that register is still held, the next result waits and no beat is taken.
module sorted_address_range_decoder_core #(
    parameter int MAX_ENTRIES = 16,
    parameter int ADDR_WIDTH  = 32
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_s_tvalid,
    output logic                               o_s_tready,
    // [31:0] address, [63:32] first_addr, [95:64] last_addr, [103:96] device_id
    input  logic [sard_pkg::IN_TDATA_W-1:0]    i_s_tdata,
    // [0] kind
    input  logic                               i_s_tuser,
    output logic                               o_m_tvalid,
    input  logic                               i_m_tready,
    // [0] hit, [8:1] device_out, [10:9] status, [15:11] zero
    output logic [sard_pkg::OUT_TDATA_W-1:0]   o_m_tdata
);

    localparam int AW = (ADDR_WIDTH < sard_pkg::FIELD_WIDTH) ? ADDR_WIDTH
                                                             : sard_pkg::FIELD_WIDTH;
    localparam int IW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int CW = $clog2(MAX_ENTRIES + 1);
    localparam int DW = sard_pkg::DEV_WIDTH;

    typedef struct packed {
        logic [DW-1:0] dev;
        logic [AW-1:0] high;
        logic [AW-1:0] low;
    } t_entry;

    sard_pkg::t_state r_state, n_state;
    logic [CW-1:0]    r_count, n_count;
    logic [IW-1:0]    r_idx, n_idx;
    logic [IW-1:0]    r_pos, n_pos;
    logic [AW-1:0]    r_addr, n_addr;
    logic [AW-1:0]    r_lo, n_lo;
    logic [AW-1:0]    r_hi, n_hi;
    logic [DW-1:0]    r_dev_in, n_dev_in;
    logic             r_hit, n_hit;
    logic [DW-1:0]    r_dev, n_dev;
    logic [1:0]       r_status, n_status;
    logic             r_m_tvalid;
    logic [sard_pkg::OUT_TDATA_W-1:0] r_m_tdata;

    logic             ram_we;
    logic [IW-1:0]    ram_waddr;
    logic [IW-1:0]    ram_raddr;
    t_entry           ram_wdata;
    t_entry           rd;
    logic             in_beat;
    logic             out_load;
    logic             last_entry;

    // Range table.
    sard_ram #(
        .WIDTH ($bits(t_entry)),
        .DEPTH (MAX_ENTRIES)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (rd)
    );

    assign o_s_tready = (r_state == sard_pkg::ST_IDLE);
    assign in_beat    = i_s_tvalid && o_s_tready;
    assign out_load   = (r_state == sard_pkg::ST_RESP) && (!r_m_tvalid || i_m_tready);
    assign last_entry = ((CW'(r_idx) + CW'(1)) == r_count);

    // Next state, table access and result.
    always_comb begin
        n_state   = r_state;
        n_count   = r_count;
        n_idx     = r_idx;
        n_pos     = r_pos;
        n_addr    = r_addr;
        n_lo      = r_lo;
        n_hi      = r_hi;
        n_dev_in  = r_dev_in;
        n_hit     = r_hit;
        n_dev     = r_dev;
        n_status  = r_status;
        ram_we    = 1'b0;
        ram_waddr = r_idx + IW'(1);
        ram_wdata = rd;
        ram_raddr = r_idx + IW'(1);

        unique case (r_state)
            sard_pkg::ST_IDLE: begin
                ram_raddr = '0;
                if (in_beat) begin
                    n_addr   = i_s_tdata[AW-1:0];
                    n_lo     = i_s_tdata[32 +: AW];
                    n_hi     = i_s_tdata[64 +: AW];
                    n_dev_in = i_s_tdata[96 +: DW];
                    n_hit    = 1'b0;
                    n_dev    = '0;
                    n_status = sard_pkg::STATUS_OK;
                    n_idx    = '0;
                    if (i_s_tuser == sard_pkg::KIND_LOOKUP) begin
                        n_state = (r_count == '0) ? sard_pkg::ST_RESP : sard_pkg::ST_LOOKUP;
                    end else if (r_count == CW'(MAX_ENTRIES)) begin
                        n_status = sard_pkg::STATUS_FULL;
                        n_state  = sard_pkg::ST_RESP;
                    end else if (n_lo > n_hi) begin
                        n_status = sard_pkg::STATUS_OVERLAP;
                        n_state  = sard_pkg::ST_RESP;
                    end else if (r_count == '0) begin
                        n_pos   = '0;
                        n_state = sard_pkg::ST_WRITE;
                    end else begin
                        n_state = sard_pkg::ST_INS_SCAN;
                    end
                end
            end

            // Walk the sorted entries until the address is passed or held, or the last entry is read.
            sard_pkg::ST_LOOKUP: begin
                if (r_addr < rd.low) begin
                    n_state = sard_pkg::ST_RESP;
                end else if (r_addr <= rd.high) begin
                    n_hit   = 1'b1;
                    n_dev   = rd.dev;
                    n_state = sard_pkg::ST_RESP;
                end else if (last_entry) begin
                    n_state = sard_pkg::ST_RESP;
                end else begin
                    n_idx = r_idx + IW'(1);
                end
            end

            // Find the slot for the new range or detect an overlap.
            sard_pkg::ST_INS_SCAN: begin
                if (rd.high < r_lo) begin
                    if (last_entry) begin
                        n_pos   = IW'(r_count);
                        n_state = sard_pkg::ST_WRITE;
                    end else begin
                        n_idx = r_idx + IW'(1);
                    end
                end else if (rd.low > r_hi) begin
                    n_pos     = r_idx;
                    n_idx     = IW'(r_count - CW'(1));
                    ram_raddr = IW'(r_count - CW'(1));
                    n_state   = sard_pkg::ST_SHIFT;
                end else begin
                    n_status = sard_pkg::STATUS_OVERLAP;
                    n_state  = sard_pkg::ST_RESP;
                end
            end

            // Move entries up one slot, highest first.
            sard_pkg::ST_SHIFT: begin
                ram_we    = 1'b1;
                ram_waddr = r_idx + IW'(1);
                ram_wdata = rd;
                ram_raddr = r_idx - IW'(1);
                if (r_idx == r_pos) begin
                    n_state = sard_pkg::ST_WRITE;
                end else begin
                    n_idx = r_idx - IW'(1);
                end
            end

            sard_pkg::ST_WRITE: begin
                ram_we         = 1'b1;
                ram_waddr      = r_pos;
                ram_wdata.low  = r_lo;
                ram_wdata.high = r_hi;
                ram_wdata.dev  = r_dev_in;
                n_count        = r_count + CW'(1);
                n_status       = sard_pkg::STATUS_OK;
                n_state        = sard_pkg::ST_RESP;
            end

            sard_pkg::ST_RESP: begin
                if (out_load) begin
                    n_state = sard_pkg::ST_IDLE;
                end
            end

            default: begin
                n_state = sard_pkg::ST_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= sard_pkg::ST_IDLE;
            r_count <= '0;
            r_idx   <= '0;
            r_pos   <= '0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_idx   <= n_idx;
            r_pos   <= n_pos;
        end
    end

    // Item and result payload registers.
    always_ff @(posedge i_clk) begin
        r_addr   <= n_addr;
        r_lo     <= n_lo;
        r_hi     <= n_hi;
        r_dev_in <= n_dev_in;
        r_hit    <= n_hit;
        r_dev    <= n_dev;
        r_status <= n_status;
    end

    // Output register: holds a result until the downstream side takes it.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_tvalid <= 1'b0;
        end else if (out_load) begin
            r_m_tvalid <= 1'b1;
        end else if (i_m_tready) begin
            r_m_tvalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_m_tdata <= {5'b0, r_status, r_dev, r_hit};
        end
    end

    assign o_m_tvalid = r_m_tvalid;
    assign o_m_tdata  = r_m_tdata;

endmodule

>>> tb/sorted_address_range_decoder_core_checker.sv
// Checker for the sorted address range decoder: predicts every result beat from the item beats.
// Depends on sard_pkg; instantiated beside the core by sorted_address_range_decoder_core_test.
module sorted_address_range_decoder_core_checker #(
    parameter int NUM_SLOTS = 16
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_s_tvalid,
    input  logic                             i_s_tready,
    // [31:0] address, [63:32] first_addr, [95:64] last_addr, [103:96] device_id
    input  logic [sard_pkg::IN_TDATA_W-1:0]  i_s_tdata,
    // [0] kind
    input  logic                             i_s_tuser,
    input  logic                             i_m_tvalid,
    input  logic                             i_m_tready,
    // [0] hit, [8:1] device_out, [10:9] status, [15:11] zero
    input  logic [sard_pkg::OUT_TDATA_W-1:0] i_m_tdata,
    output int                               o_mismatches,
    output int                               o_outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    // One result beat, laid out as in the low bits of tdata.
    typedef struct packed {
        logic [1:0]                     status;
        logic [sard_pkg::DEV_WIDTH-1:0] device;
        logic                           hit;
    } t_answer;

    // Shadow copy of the range table, kept sorted by address.
    logic [sard_pkg::FIELD_WIDTH-1:0] span_low  [NUM_SLOTS];
    logic [sard_pkg::FIELD_WIDTH-1:0] span_high [NUM_SLOTS];
    logic [sard_pkg::DEV_WIDTH-1:0]   span_dev  [NUM_SLOTS];
    int                               span_count = 0;

    t_answer pending_answers[$];
    int      mismatch_count = 0;
    int      result_index   = 0;

    // Finds the range that holds an address; a miss answers all zeros.
    function automatic t_answer decode_address(
        input logic [sard_pkg::FIELD_WIDTH-1:0] addr);
        t_answer ans;
        ans = '0;
        for (int i = 0; i < span_count; i++) begin
            if (addr >= span_low[i] && addr <= span_high[i]) begin
                ans.hit    = 1'b1;
                ans.device = span_dev[i];
                return ans;
            end
        end
        return ans;
    endfunction

    // Inserts a range at its sorted place and returns the insert status.
    // A full table is refused before any overlap or inversion is looked at.
    function automatic logic [1:0] place_range(
        input logic [sard_pkg::FIELD_WIDTH-1:0] lo,
        input logic [sard_pkg::FIELD_WIDTH-1:0] hi,
        input logic [sard_pkg::DEV_WIDTH-1:0]   dev);
        int pos;
        if (span_count >= NUM_SLOTS)
            return sard_pkg::STATUS_FULL;
        if (lo > hi)
            return sard_pkg::STATUS_OVERLAP;
        pos = span_count;
        for (int i = 0; i < span_count; i++) begin
            if (span_high[i] < lo)
                continue;
            if (span_low[i] > hi) begin
                pos = i;
                break;
            end
            return sard_pkg::STATUS_OVERLAP;
        end
        for (int i = span_count; i > pos; i--) begin
            span_low[i]  = span_low[i-1];
            span_high[i] = span_high[i-1];
            span_dev[i]  = span_dev[i-1];
        end
        span_low[pos]  = lo;
        span_high[pos] = hi;
        span_dev[pos]  = dev;
        span_count++;
        return sard_pkg::STATUS_OK;
    endfunction

    // Prints one line per mismatch and counts it.
    task automatic report_mismatch(input string what, input int unsigned got,
                                   input int unsigned want);
        mismatch_count++;
        $display("[%0t] result %0d: %s is 0x%0h, expected 0x%0h",
                 $time, result_index, what, got, want);
    endtask

    // Results are checked before the item of the same edge is predicted, so a
    // beat can never be matched against an expectation raised at its own edge.
    always @(posedge i_clk) begin
        t_answer got;
        t_answer want;
        if (!i_rst_n) begin
            span_count = 0;
            pending_answers.delete();
        end else begin
            if (i_m_tvalid && i_m_tready) begin
                got = t_answer'(i_m_tdata[10:0]);
                if (pending_answers.size() == 0) begin
                    report_mismatch("result beat with nothing pending",
                                    32'(i_m_tdata), 32'd0);
                end else begin
                    want = pending_answers.pop_front();
                    if (got.hit !== want.hit)
                        report_mismatch("hit", 32'(got.hit), 32'(want.hit));
                    if (got.device !== want.device)
                        report_mismatch("device_out", 32'(got.device), 32'(want.device));
                    if (got.status !== want.status)
                        report_mismatch("status", 32'(got.status), 32'(want.status));
                    if (i_m_tdata[sard_pkg::OUT_TDATA_W-1:11] !== '0)
                        report_mismatch("padding",
                                        32'(i_m_tdata[sard_pkg::OUT_TDATA_W-1:11]), 32'd0);
                end
                result_index++;
            end
            if (i_s_tvalid && i_s_tready) begin
                want = '0;
                if (i_s_tuser == sard_pkg::KIND_LOOKUP)
                    want = decode_address(i_s_tdata[31:0]);
                else
                    want.status = place_range(i_s_tdata[63:32], i_s_tdata[95:64],
                                              i_s_tdata[103:96]);
                pending_answers.push_back(want);
            end
        end
        o_mismatches  <= mismatch_count;
        o_outstanding <= pending_answers.size();
    end

endmodule

>>> tb/sorted_address_range_decoder_core_test.sv
// Top of the decoder testbench: clock, reset, item stimulus, result back-pressure and verdict.
// Depends on sard_pkg, sorted_address_range_decoder_core and its checker module.
module sorted_address_range_decoder_core_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NUM_SLOTS    = 16;
    localparam int RANDOM_ITEMS = 480;
    localparam int DRAIN_CYCLES = 64;
    localparam int CYCLE_LIMIT  = 400000;

    // Back-pressure modes of the result side.
    localparam int RX_OPEN   = 0;
    localparam int RX_COIN   = 1;
    localparam int RX_SPARSE = 2;
    localparam int RX_PERIOD = 3;

    logic                             i_clk;
    logic                             i_rst_n;
    logic                             i_s_tvalid;
    logic                             o_s_tready;
    logic [sard_pkg::IN_TDATA_W-1:0]  i_s_tdata;
    logic                             i_s_tuser;
    logic                             o_m_tvalid;
    logic                             i_m_tready = 1'b0;
    logic [sard_pkg::OUT_TDATA_W-1:0] o_m_tdata;

    int mismatches;
    int outstanding;
    int cycle_count = 0;
    int rx_mode     = RX_OPEN;
    int rx_left     = 0;
    int burst_left  = 0;

    // Well-formed ranges offered so far, kept to aim lookups and overlaps at them.
    logic [31:0] tried_lo[$];
    logic [31:0] tried_hi[$];

    sorted_address_range_decoder_core #(
        .MAX_ENTRIES(NUM_SLOTS),
        .ADDR_WIDTH (sard_pkg::FIELD_WIDTH)
    ) uut (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_s_tvalid(i_s_tvalid),
        .o_s_tready(o_s_tready),
        .i_s_tdata (i_s_tdata),
        .i_s_tuser (i_s_tuser),
        .o_m_tvalid(o_m_tvalid),
        .i_m_tready(i_m_tready),
        .o_m_tdata (o_m_tdata)
    );

    sorted_address_range_decoder_core_checker #(
        .NUM_SLOTS(NUM_SLOTS)
    ) u_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_s_tvalid   (i_s_tvalid),
        .i_s_tready   (o_s_tready),
        .i_s_tdata    (i_s_tdata),
        .i_s_tuser    (i_s_tuser),
        .i_m_tvalid   (o_m_tvalid),
        .i_m_tready   (i_m_tready),
        .i_m_tdata    (o_m_tdata),
        .o_mismatches (mismatches),
        .o_outstanding(outstanding)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // Run limit: a stuck handshake or a lost result ends here.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    // Result side: ready follows a mode that is drawn anew whenever its spell runs out,
    // from always open through coin flips to mostly stalled.
    always @(posedge i_clk) begin
        if (rx_left == 0) begin
            rx_mode <= $urandom_range(RX_OPEN, RX_PERIOD);
            rx_left <= $urandom_range(20, 200);
        end else begin
            rx_left <= rx_left - 1;
        end
        case (rx_mode)
            RX_OPEN:   i_m_tready <= 1'b1;
            RX_COIN:   i_m_tready <= 1'($urandom_range(0, 1));
            RX_SPARSE: i_m_tready <= ($urandom_range(0, 3) == 0);
            default:   i_m_tready <= (cycle_count % 7) > 2;
        endcase
    end

    // Offers one item beat and returns at the edge that takes it. Beats go out
    // in bursts; a gap with valid low follows each burst.
    task automatic send_item(input logic kind, input logic [31:0] addr,
                             input logic [31:0] lo, input logic [31:0] hi,
                             input logic [7:0] dev);
        if (burst_left == 0) begin
            i_s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge i_clk);
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 80)
                                                     : $urandom_range(1, 8);
        end
        i_s_tuser  <= kind;
        i_s_tdata  <= {dev, hi, lo, addr};
        i_s_tvalid <= 1'b1;
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
        burst_left--;
    endtask

    // A lookup carries random content in the fields it does not use.
    task automatic send_lookup(input logic [31:0] addr);
        send_item(sard_pkg::KIND_LOOKUP, addr, $urandom, $urandom,
                  8'($urandom_range(0, 255)));
    endtask

    task automatic send_insert(input logic [31:0] lo, input logic [31:0] hi,
                               input logic [7:0] dev);
        if (lo <= hi) begin
            tried_lo.push_back(lo);
            tried_hi.push_back(hi);
        end
        send_item(sard_pkg::KIND_INSERT, $urandom, lo, hi, dev);
    endtask

    // A random address within one of the offered ranges.
    function automatic logic [31:0] point_in(input int idx);
        logic [63:0] width;
        width = {32'd0, tried_hi[idx]} - {32'd0, tried_lo[idx]} + 64'd1;
        return tried_lo[idx] + 32'(64'($urandom) % width);
    endfunction

    initial begin
        logic [5:0]  slot;
        logic [31:0] lo;
        logic [31:0] hi;
        logic [31:0] len;
        logic [31:0] probe;
        int          pick;
        int          idx;

        i_rst_n    <= 1'b0;
        i_s_tvalid <= 1'b0;
        i_s_tuser  <= sard_pkg::KIND_LOOKUP;
        i_s_tdata  <= '0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: empty table, boundaries, refusals, shifts at front and middle.
        send_lookup(32'h0000_0000);
        send_lookup(32'hFFFF_FFFF);
        send_insert(32'h0000_1000, 32'h0000_1FFF, 8'hAA);
        send_lookup(32'h0000_0FFF);
        send_lookup(32'h0000_1000);
        send_lookup(32'h0000_1FFF);
        send_lookup(32'h0000_2000);
        send_insert(32'h0000_3000, 32'h0000_2FFF, 8'h11);
        send_insert(32'h0000_1800, 32'h0000_2800, 8'h22);
        send_insert(32'h0000_0F00, 32'h0000_1000, 8'h23);
        send_insert(32'h0000_1FFF, 32'h0000_1FFF, 8'h24);
        send_insert(32'h0000_0000, 32'h0000_0000, 8'h00);
        send_insert(32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'hFF);
        send_insert(32'h0000_2000, 32'h0000_2FFF, 8'h55);
        send_insert(32'h0000_0000, 32'hFFFF_FFFF, 8'h77);
        send_lookup(32'h0000_0000);
        send_lookup(32'h0000_0001);
        send_lookup(32'h0000_2000);
        send_lookup(32'hFFFF_FFFE);
        send_lookup(32'hFFFF_FFFF);

        // Random: mostly lookups aimed at known ranges, with inserts that fill
        // the table gradually and then keep hitting the full refusal.
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if ($urandom_range(0, 99) < 22) begin
                pick = $urandom_range(0, 99);
                if (pick < 70) begin
                    // Well-formed range inside one of 64 address slots.
                    slot = 6'($urandom_range(0, 63));
                    case ($urandom_range(0, 3))
                        0:       len = $urandom_range(1, 16);
                        1:       len = $urandom_range(1, 4096);
                        2:       len = $urandom_range(1, 32'h0400_0000);
                        default: len = $urandom_range(1, 256);
                    endcase
                    case ($urandom_range(0, 7))
                        0:       lo = {slot, 26'd0};
                        1:       lo = {slot, 26'd0} + (32'h0400_0000 - len);
                        default: lo = {slot, 26'd0} + $urandom_range(0, 32'h0400_0000 - len);
                    endcase
                    hi = lo + len - 32'd1;
                end else if (pick < 85 && tried_lo.size() != 0) begin
                    // Range that touches an offered one.
                    idx   = $urandom_range(0, tried_lo.size() - 1);
                    probe = point_in(idx);
                    len   = $urandom_range(0, 8);
                    lo    = (probe < len) ? 32'd0 : probe - len;
                    len   = $urandom_range(0, 8);
                    hi    = (probe > 32'hFFFF_FFFF - len) ? 32'hFFFF_FFFF : probe + len;
                end else begin
                    // Noise: often inverted, often wide.
                    lo = $urandom;
                    hi = $urandom;
                end
                send_insert(lo, hi, 8'($urandom_range(0, 255)));
            end else if (tried_lo.size() != 0 && $urandom_range(0, 9) < 6) begin
                idx = $urandom_range(0, tried_lo.size() - 1);
                case ($urandom_range(0, 4))
                    0:       send_lookup(tried_lo[idx]);
                    1:       send_lookup(tried_hi[idx]);
                    2:       send_lookup(tried_lo[idx] - 32'd1);
                    3:       send_lookup(tried_hi[idx] + 32'd1);
                    default: send_lookup(point_in(idx));
                endcase
            end else begin
                send_lookup($urandom);
            end
        end

        // Drain: wait for every pending result, then let the core settle.
        i_s_tvalid <= 1'b0;
        @(posedge i_clk);
        while (outstanding != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatches == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

>>> files.f
hdl/sard_pkg.sv
hdl/sard_ram.sv
hdl/sorted_address_range_decoder_core.sv
tb/sorted_address_range_decoder_core_checker.sv
tb/sorted_address_range_decoder_core_test.sv
